### design/cpu_alu_flag_unit_assert.svh
// ----------------------------------------------------------------------------
// cpu_alu_flag_unit assertion macros
// Concurrent assertion wrappers, compiled out when NO_ASSERTIONS is set.
// ----------------------------------------------------------------------------
`ifndef CPU_ALU_FLAG_UNIT_ASSERT_SVH
`define CPU_ALU_FLAG_UNIT_ASSERT_SVH

`ifndef NO_ASSERTIONS

`define CAF_ASSERT(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("caf assertion failed");

`define CAF_ASSERT_NEVER(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) not (prop)) \
		else $error("caf forbidden condition seen");

`else

`define CAF_ASSERT(lbl, clk, rst_n, prop)

`define CAF_ASSERT_NEVER(lbl, clk, rst_n, prop)

`endif

`endif

### design/caf_pkg.sv
// ----------------------------------------------------------------------------
// caf_pkg
// Types and opcode field codes for the accumulator and flag unit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package caf_pkg;

	// flag bit positions
	localparam int unsigned FLAG_Z = 3;
	localparam int unsigned FLAG_N = 2;
	localparam int unsigned FLAG_H = 1;
	localparam int unsigned FLAG_C = 0;

	localparam logic [7:0] ACC_RESET   = 8'h01;
	localparam logic [3:0] FLAGS_RESET = 4'b1000;

	// register field code for A
	localparam logic [2:0] REG_A = 3'd7;

	// opcode quadrant, op[7:6]
	localparam logic [1:0] QUAD_MISC = 2'd0;
	localparam logic [1:0] QUAD_ALU  = 2'd2;
	localparam logic [1:0] QUAD_IMM  = 2'd3;

	// prefixed group, op[7:6]
	localparam logic [1:0] GRP_SHIFT = 2'd0;
	localparam logic [1:0] GRP_BIT   = 2'd1;
	localparam logic [1:0] GRP_RES   = 2'd2;
	localparam logic [1:0] GRP_SET   = 2'd3;

	// low opcode field, op[2:0]
	localparam logic [2:0] LOW_INC = 3'd4;
	localparam logic [2:0] LOW_DEC = 3'd5;
	localparam logic [2:0] LOW_IMM = 3'd6;
	localparam logic [2:0] LOW_ACC = 3'd7;

	// ALU operation, op[5:3]
	localparam logic [2:0] ALU_ADD = 3'd0;
	localparam logic [2:0] ALU_ADC = 3'd1;
	localparam logic [2:0] ALU_SUB = 3'd2;
	localparam logic [2:0] ALU_SBC = 3'd3;
	localparam logic [2:0] ALU_AND = 3'd4;
	localparam logic [2:0] ALU_XOR = 3'd5;
	localparam logic [2:0] ALU_OR  = 3'd6;
	localparam logic [2:0] ALU_CP  = 3'd7;

	// rotate / shift operation
	localparam logic [2:0] SH_RLC  = 3'd0;
	localparam logic [2:0] SH_RRC  = 3'd1;
	localparam logic [2:0] SH_RL   = 3'd2;
	localparam logic [2:0] SH_RR   = 3'd3;
	localparam logic [2:0] SH_SLA  = 3'd4;
	localparam logic [2:0] SH_SRA  = 3'd5;
	localparam logic [2:0] SH_SWAP = 3'd6;
	localparam logic [2:0] SH_SRL  = 3'd7;

	// accumulator misc operation, op[5:3] with low field 7
	localparam logic [2:0] ACC_RLCA = 3'd0;
	localparam logic [2:0] ACC_RRCA = 3'd1;
	localparam logic [2:0] ACC_RLA  = 3'd2;
	localparam logic [2:0] ACC_RRA  = 3'd3;
	localparam logic [2:0] ACC_DAA  = 3'd4;
	localparam logic [2:0] ACC_CPL  = 3'd5;
	localparam logic [2:0] ACC_SCF  = 3'd6;
	localparam logic [2:0] ACC_CCF  = 3'd7;

	// decimal adjust
	localparam logic [7:0] DAA_HI_MAX  = 8'h99;
	localparam logic [7:0] DAA_ADJ_HI  = 8'h60;
	localparam logic [7:0] DAA_ADJ_LO  = 8'h06;
	localparam logic [3:0] DAA_NIB_MAX = 4'h9;

	typedef struct packed {
		logic [7:0] acc;
		logic [3:0] flags;
	} arch_state_t;

	typedef struct packed {
		logic [7:0] result;
		logic       write_back;
		logic [7:0] acc;
		logic [3:0] flags;
		logic       status;
	} exec_res_t;

endpackage

### design/caf_if.sv
// ----------------------------------------------------------------------------
// caf_if
// Valid/ready channels for instruction and result transfers.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface caf_cmd_if;
	logic       valid;
	logic       ready;
	logic [7:0] op;
	logic       prefixed;
	logic [7:0] operand;

	modport source (output valid, output op, output prefixed, output operand, input ready);
	modport sink   (input valid, input op, input prefixed, input operand, output ready);
endinterface

interface caf_rsp_if;
	logic       valid;
	logic       ready;
	logic [7:0] result;
	logic       write_back;
	logic [7:0] acc_out;
	logic [3:0] flags_out;
	logic       status;

	modport source (output valid, output result, output write_back, output acc_out,
		output flags_out, output status, input ready);
	modport sink   (input valid, input result, input write_back, input acc_out,
		input flags_out, input status, output ready);
endinterface

### design/caf_exec.sv
// ----------------------------------------------------------------------------
// caf_exec
// Single-pass decode and execute of one instruction against A and flags.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module caf_exec
	import caf_pkg::*;
(
	input  logic [7:0]  op,
	input  logic        prefixed,
	input  logic [7:0]  operand,
	input  arch_state_t cur,
	output exec_res_t   ex
);

	// returns {carry out, byte}
	function automatic logic [8:0] shift_f(input logic [2:0] g, input logic [7:0] x,
		input logic cin);
		logic [7:0] r;
		logic       co;
		co = 1'b0;
		r  = x;
		unique case (g)
			SH_RLC: begin co = x[7]; r = {x[6:0], x[7]}; end
			SH_RRC: begin co = x[0]; r = {x[0], x[7:1]}; end
			SH_RL: begin co = x[7]; r = {x[6:0], cin}; end
			SH_RR: begin co = x[0]; r = {cin, x[7:1]}; end
			SH_SLA: begin co = x[7]; r = {x[6:0], 1'b0}; end
			SH_SRA: begin co = x[0]; r = {x[7], x[7:1]}; end
			SH_SWAP: begin r = {x[3:0], x[7:4]}; end
			SH_SRL: begin co = x[0]; r = {1'b0, x[7:1]}; end
		endcase
		return {co, r};
	endfunction

	// returns {Z N H C, byte}
	function automatic logic [11:0] alu_f(input logic [2:0] k, input logic [7:0] a,
		input logic [7:0] v, input logic cin);
		logic [8:0] w;
		logic [4:0] n;
		logic [7:0] r;
		logic       cy, nf, h, c;
		cy = (k == ALU_ADC || k == ALU_SBC) ? cin : 1'b0;
		w  = '0;
		n  = '0;
		r  = '0;
		nf = 1'b0;
		h  = 1'b0;
		c  = 1'b0;
		unique case (k)
			ALU_ADD, ALU_ADC: begin
				w = {1'b0, a} + {1'b0, v} + {8'h00, cy};
				n = {1'b0, a[3:0]} + {1'b0, v[3:0]} + {4'h0, cy};
				r = w[7:0];
				h = n[4];
				c = w[8];
			end
			ALU_SUB, ALU_SBC, ALU_CP: begin
				w  = {1'b0, a} - {1'b0, v} - {8'h00, cy};
				n  = {1'b0, a[3:0]} - {1'b0, v[3:0]} - {4'h0, cy};
				r  = w[7:0];
				nf = 1'b1;
				h  = n[4];
				c  = w[8];
			end
			ALU_AND: begin r = a & v; h = 1'b1; end
			ALU_XOR: r = a ^ v;
			ALU_OR: r = a | v;
		endcase
		return {(r == 8'h00), nf, h, c, r};
	endfunction

	logic [7:0] x, res, ra, dv, acc_n;
	logic [3:0] fa, fl_n;
	logic [2:0] bitn;
	logic       co, dc, wb, st, cin;

	always_comb begin
		cin   = cur.flags[FLAG_C];
		x     = operand;
		res   = 8'h00;
		ra    = 8'h00;
		fa    = 4'h0;
		dv    = cur.acc;
		dc    = cin;
		co    = 1'b0;
		bitn  = op[5:3];
		wb    = 1'b0;
		st    = 1'b0;
		acc_n = cur.acc;
		fl_n  = cur.flags;

		priority if (prefixed) begin
			x = (op[2:0] == REG_A) ? cur.acc : operand;
			unique case (op[7:6])
				GRP_SHIFT: begin
					{co, res} = shift_f(bitn, x, cin);
					fl_n = {(res == 8'h00), 1'b0, 1'b0, co};
					wb = 1'b1;
				end
				GRP_BIT: begin
					res  = x;
					fl_n = {~x[bitn], 1'b0, 1'b1, cin};
				end
				GRP_RES: begin
					res = x & ~(8'h01 << bitn);
					wb  = 1'b1;
				end
				GRP_SET: begin
					res = x | (8'h01 << bitn);
					wb  = 1'b1;
				end
			endcase
			if (wb && op[2:0] == REG_A) begin
				acc_n = res;
			end
		end else if (op[7:6] == QUAD_ALU || (op[7:6] == QUAD_IMM && op[2:0] == LOW_IMM)) begin
			if (op[7:6] == QUAD_ALU && op[2:0] == REG_A) begin
				x = cur.acc;
			end
			{fa, ra} = alu_f(op[5:3], cur.acc, x, cin);
			fl_n = fa;
			if (op[5:3] == ALU_CP) begin
				res = cur.acc;
			end else begin
				res   = ra;
				wb    = 1'b1;
				acc_n = ra;
			end
		end else if (op[7:6] == QUAD_MISC && (op[2:0] == LOW_INC || op[2:0] == LOW_DEC)) begin
			x = (op[5:3] == REG_A) ? cur.acc : operand;
			if (op[2:0] == LOW_INC) begin
				res  = x + 8'd1;
				fl_n = {(res == 8'h00), 1'b0, (x[3:0] == 4'hF), cin};
			end else begin
				res  = x - 8'd1;
				fl_n = {(res == 8'h00), 1'b1, (x[3:0] == 4'h0), cin};
			end
			wb = 1'b1;
			if (op[5:3] == REG_A) begin
				acc_n = res;
			end
		end else if (op[7:6] == QUAD_MISC && op[2:0] == LOW_ACC) begin
			unique case (op[5:3])
				ACC_RLCA, ACC_RRCA, ACC_RLA, ACC_RRA: begin
					{co, res} = shift_f(op[5:3], cur.acc, cin);
					fl_n  = {3'b000, co};
					wb    = 1'b1;
					acc_n = res;
				end
				ACC_DAA: begin
					if (!cur.flags[FLAG_N]) begin
						if (dc || cur.acc > DAA_HI_MAX) begin
							dv = dv + DAA_ADJ_HI;
							dc = 1'b1;
						end
						if (cur.flags[FLAG_H] || dv[3:0] > DAA_NIB_MAX) begin
							dv = dv + DAA_ADJ_LO;
						end
					end else begin
						if (dc) begin
							dv = dv - DAA_ADJ_HI;
						end
						if (cur.flags[FLAG_H]) begin
							dv = dv - DAA_ADJ_LO;
						end
					end
					res   = dv;
					fl_n  = {(dv == 8'h00), cur.flags[FLAG_N], 1'b0, dc};
					wb    = 1'b1;
					acc_n = dv;
				end
				ACC_CPL: begin
					res   = ~cur.acc;
					fl_n  = {cur.flags[FLAG_Z], 1'b1, 1'b1, cin};
					wb    = 1'b1;
					acc_n = res;
				end
				ACC_SCF: begin
					res  = cur.acc;
					fl_n = {cur.flags[FLAG_Z], 1'b0, 1'b0, 1'b1};
				end
				ACC_CCF: begin
					res  = cur.acc;
					fl_n = {cur.flags[FLAG_Z], 1'b0, 1'b0, ~cin};
				end
			endcase
		end else begin
			st = 1'b1;
		end

		ex.result     = res;
		ex.write_back = wb;
		ex.acc        = acc_n;
		ex.flags      = fl_n;
		ex.status     = st;
	end

endmodule

### design/caf_state.sv
// ----------------------------------------------------------------------------
// caf_state
// Architectural accumulator and flag registers.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module caf_state
	import caf_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        upd,
	input  arch_state_t nxt,
	output arch_state_t cur
);

	logic [7:0] acc_q;
	logic [3:0] flags_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q   <= ACC_RESET;
			flags_q <= FLAGS_RESET;
		end else if (upd) begin
			acc_q   <= nxt.acc;
			flags_q <= nxt.flags;
		end
	end

	assign cur.acc   = acc_q;
	assign cur.flags = flags_q;

endmodule

### design/cpu_alu_flag_unit.sv
// ----------------------------------------------------------------------------
// cpu_alu_flag_unit
// 8-bit accumulator and flag instruction unit with A and ZNHC state.
// ----------------------------------------------------------------------------
// channel  dir  handshake      payload
// cmd      in   valid / ready  op, prefixed, operand
// rsp      out  valid / ready  result, write_back, acc_out, flags_out, status
//
// One instruction per clock while rsp is not stalled; rsp valid follows the cmd
// transfer through the input register, then execute into the result register.
// A and the flags update as the instruction leaves the input register, so the
// next instruction sees them the following cycle.
// Reset sets A to 0x01 and the flags to Z only; both stages empty.
// A stalled rsp holds the result register; cmd keeps taking one more item.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "cpu_alu_flag_unit_assert.svh"

module cpu_alu_flag_unit
	import caf_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	caf_cmd_if.sink  cmd,
	caf_rsp_if.source rsp
);

	logic        vld_s1, vld_s2, adv;
	logic [7:0]  op_s1, operand_s1;
	logic        prefixed_s1;
	exec_res_t   ex, res_s2;
	arch_state_t cur, nxt;

	assign adv       = vld_s1 && (!vld_s2 || rsp.ready);
	assign cmd.ready = !vld_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (cmd.valid && cmd.ready) begin
			vld_s1 <= 1'b1;
		end else if (adv) begin
			vld_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.valid && cmd.ready) begin
			op_s1       <= cmd.op;
			prefixed_s1 <= cmd.prefixed;
			operand_s1  <= cmd.operand;
		end
	end

	caf_exec u_exec (
		.op       (op_s1),
		.prefixed (prefixed_s1),
		.operand  (operand_s1),
		.cur      (cur),
		.ex       (ex)
	);

	assign nxt.acc   = ex.acc;
	assign nxt.flags = ex.flags;

	caf_state u_state (
		.clk    (clk),
		.arst_n (arst_n),
		.upd    (adv && !ex.status),
		.nxt    (nxt),
		.cur    (cur)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (adv) begin
			vld_s2 <= 1'b1;
		end else if (rsp.ready) begin
			vld_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			res_s2 <= ex;
		end
	end

	assign rsp.valid      = vld_s2;
	assign rsp.result     = res_s2.result;
	assign rsp.write_back = res_s2.write_back;
	assign rsp.acc_out    = res_s2.acc;
	assign rsp.flags_out  = res_s2.flags;
	assign rsp.status     = res_s2.status;

	// state seen by the next item matches the last result delivered
	`CAF_ASSERT(a_state_tracks_rsp, clk, arst_n, vld_s2 |-> (cur.acc == res_s2.acc && cur.flags == res_s2.flags))
	// unsupported opcode never writes back and returns a zero byte
	`CAF_ASSERT_NEVER(a_unsup_quiet, clk, arst_n, vld_s2 && res_s2.status && (res_s2.write_back || res_s2.result != 8'h00))
	// an item in the input register is never dropped
	`CAF_ASSERT(a_s1_kept, clk, arst_n, vld_s1 && !adv |=> vld_s1)

endmodule
